>>> rtl/stt_pkg.sv
package stt_pkg;

	// Field widths of one beat
	localparam int CMD_W  = 2;
	localparam int SEL_W  = 2;
	localparam int DATA_W = 32;

	// Default geometry
	localparam int COUNT_WIDTH_DEF = 24;
	localparam int SLOW_DIVIDE_DEF = 8;

	// Control register bit positions
	localparam int CTRL_EN_BIT    = 0;
	localparam int CTRL_IE_BIT    = 1;
	localparam int CTRL_CLK_BIT   = 2;
	localparam int CTRL_ONE_BIT   = 3;
	localparam int CTRL_FLAG_BIT  = 16;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK  = 2'd0,
		CMD_READ  = 2'd1,
		CMD_WRITE = 2'd2
	} cmd_t;

	typedef enum logic [SEL_W-1:0] {
		REG_CTRL    = 2'd0,
		REG_RELOAD  = 2'd1,
		REG_CURRENT = 2'd2
	} reg_sel_t;

endpackage

>>> rtl/stt_core.sv
module stt_core #(
	parameter int COUNT_WIDTH = stt_pkg::COUNT_WIDTH_DEF,
	parameter int SLOW_DIVIDE = stt_pkg::SLOW_DIVIDE_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      go,
	input  logic [stt_pkg::CMD_W-1:0] cmd,
	input  logic [stt_pkg::SEL_W-1:0] reg_sel,
	input  logic [stt_pkg::DATA_W-1:0] write_data,
	output logic [stt_pkg::DATA_W-1:0] read_data,
	output logic                      irq
);
	import stt_pkg::*;

	localparam int PW = $clog2(SLOW_DIVIDE);
	localparam logic [PW-1:0] PRE_LAST = PW'(SLOW_DIVIDE - 1);

	logic                   en_q, ie_q, clk_sel_q, one_q, flag_q;
	logic                   en_d, ie_d, clk_sel_d, one_d, flag_d;
	logic [COUNT_WIDTH-1:0] reload_q, reload_d, cur_q, cur_d, cur_dec;
	logic [PW-1:0]          pre_q, pre_d;
	logic                   count_go;

	assign cur_dec = cur_q - COUNT_WIDTH'(1);

	always_comb begin
		en_d      = en_q;
		ie_d      = ie_q;
		clk_sel_d = clk_sel_q;
		one_d     = one_q;
		flag_d    = flag_q;
		reload_d  = reload_q;
		cur_d     = cur_q;
		pre_d     = pre_q;
		count_go  = 1'b0;
		read_data = '0;
		irq       = 1'b0;

		unique case (cmd)
			CMD_TICK: begin
				if (en_q) begin
					if (clk_sel_q) begin
						count_go = 1'b1;
					end else if (pre_q == PRE_LAST) begin
						pre_d    = '0;
						count_go = 1'b1;
					end else begin
						pre_d = pre_q + PW'(1);
					end
				end
			end
			CMD_READ: begin
				unique case (reg_sel)
					REG_CTRL: begin
						read_data[CTRL_EN_BIT]   = en_q;
						read_data[CTRL_IE_BIT]   = ie_q;
						read_data[CTRL_CLK_BIT]  = clk_sel_q;
						read_data[CTRL_ONE_BIT]  = one_q;
						read_data[CTRL_FLAG_BIT] = flag_q;
						flag_d = 1'b0;
					end
					REG_RELOAD:  read_data = DATA_W'(reload_q);
					REG_CURRENT: read_data = DATA_W'(cur_q);
					default: ;
				endcase
			end
			CMD_WRITE: begin
				unique case (reg_sel)
					REG_CTRL: begin
						en_d      = write_data[CTRL_EN_BIT];
						ie_d      = write_data[CTRL_IE_BIT];
						clk_sel_d = write_data[CTRL_CLK_BIT];
						one_d     = write_data[CTRL_ONE_BIT];
					end
					REG_RELOAD: reload_d = write_data[COUNT_WIDTH-1:0];
					REG_CURRENT: begin
						cur_d  = '0;
						flag_d = 1'b0;
					end
					default: ;
				endcase
			end
			default: ;
		endcase

		// one count of the down counter
		if (count_go) begin
			if (cur_q == '0) begin
				cur_d = reload_q;
			end else begin
				cur_d = cur_dec;
				if (cur_dec == '0) begin
					flag_d = 1'b1;
					irq    = ie_q;
					if (one_q) begin
						en_d     = 1'b0;
						ie_d     = 1'b0;
						reload_d = '0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q      <= 1'b0;
			ie_q      <= 1'b0;
			clk_sel_q <= 1'b0;
			one_q     <= 1'b0;
			flag_q    <= 1'b0;
			reload_q  <= '0;
			cur_q     <= '0;
			pre_q     <= '0;
		end else if (go) begin
			en_q      <= en_d;
			ie_q      <= ie_d;
			clk_sel_q <= clk_sel_d;
			one_q     <= one_d;
			flag_q    <= flag_d;
			reload_q  <= reload_d;
			cur_q     <= cur_d;
			pre_q     <= pre_d;
		end
	end

endmodule

>>> rtl/system_tick_down_counter_unit.sv
// System tick down counter.
// Input channel (item_valid / item_stall) carries one beat per command:
//   cmd 0 is one core clock tick, 1 a register read, 2 a register write;
//   reg_sel picks control, reload or current value; write_data feeds writes.
// Output channel (result_valid / result_stall) returns one beat per input
//   beat, in order: read_data holds the register on a read and zero otherwise,
//   irq is high on the tick that brought the counter to zero with the
//   interrupt enabled.
// Pipeline: an accepted beat is registered into the input stage; when it
//   advances it updates the timer state and is registered into the result
//   register, which drives read_data, irq and result_valid.
// Throughput: one beat per cycle while the result register is not stalled,
//   set by the single counter update pass between input and result registers.
// Reset: arst_n clears every timer register, the prescaler and both pipeline
//   valids; item_stall is low out of reset, so the block is ready for a beat.
// Stall: while result_stall holds a pending result, the input stage keeps
//   its beat and item_stall rises once it is full; the result holds steady.
module system_tick_down_counter_unit #(
	parameter int COUNT_WIDTH = stt_pkg::COUNT_WIDTH_DEF,
	parameter int SLOW_DIVIDE = stt_pkg::SLOW_DIVIDE_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       item_valid,
	output logic                       item_stall,
	input  logic [stt_pkg::CMD_W-1:0]  cmd,
	input  logic [stt_pkg::SEL_W-1:0]  reg_sel,
	input  logic [stt_pkg::DATA_W-1:0] write_data,
	output logic                       result_valid,
	input  logic                       result_stall,
	output logic [stt_pkg::DATA_W-1:0] read_data,
	output logic                       irq
);
	import stt_pkg::*;

	// input stage
	logic              valid_s1;
	logic [CMD_W-1:0]  cmd_s1;
	logic [SEL_W-1:0]  sel_s1;
	logic [DATA_W-1:0] data_s1;

	// result register
	logic              res_valid_q;
	logic [DATA_W-1:0] rd_q;
	logic              irq_q;

	logic              out_blocked;
	logic              advance;
	logic [DATA_W-1:0] rd_c;
	logic              irq_c;

	// The result register is blocked only while it holds a beat the sink stalls.
	assign out_blocked = res_valid_q & result_stall;
	assign advance     = valid_s1 & ~out_blocked;
	assign item_stall  = valid_s1 & out_blocked;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	// Capture a new beat whenever the stage is free or moving on.
	always_ff @(posedge clk) begin
		if (!item_stall && item_valid) begin
			cmd_s1  <= cmd;
			sel_s1  <= reg_sel;
			data_s1 <= write_data;
		end
	end

	stt_core #(
		.COUNT_WIDTH(COUNT_WIDTH),
		.SLOW_DIVIDE(SLOW_DIVIDE)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (advance),
		.cmd       (cmd_s1),
		.reg_sel   (sel_s1),
		.write_data(data_s1),
		.read_data (rd_c),
		.irq       (irq_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	// Hold the result payload while it is stalled.
	always_ff @(posedge clk) begin
		if (advance) begin
			rd_q  <= rd_c;
			irq_q <= irq_c;
		end
	end

	assign result_valid = res_valid_q;
	assign read_data    = rd_q;
	assign irq          = irq_q;

endmodule

>>> rtl/stt_checker.sv
module stt_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       item_valid,
	input logic                       item_stall,
	input logic                       result_valid,
	input logic                       result_stall,
	input logic [stt_pkg::DATA_W-1:0] read_data,
	input logic                       irq
);
	import stt_pkg::*;

	// A stalled result holds.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(read_data) && $stable(irq))
		else $error("stalled result changed");

	// An interrupt only comes from a tick, which reads nothing.
	a_irq_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && irq |-> read_data == '0)
		else $error("irq beat carries read data");

	// An accepted beat that the input stage does not hold back shows up as a result.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$past(item_valid && !item_stall, 2) && !$past(item_stall) |-> result_valid)
		else $error("accepted beat produced no result");

	// Reset empties the output.
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |-> !result_valid && !item_stall)
		else $error("output valid during reset");

endmodule

bind system_tick_down_counter_unit stt_checker u_stt_checker (.*);

>>> dv/stt_timer_checker.sv
`timescale 1ns / 100ps

module stt_timer_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       item_valid,
	input  logic                       item_stall,
	input  logic [stt_pkg::CMD_W-1:0]  cmd,
	input  logic [stt_pkg::SEL_W-1:0]  reg_sel,
	input  logic [stt_pkg::DATA_W-1:0] write_data,
	input  logic                       result_valid,
	input  logic                       result_stall,
	input  logic [stt_pkg::DATA_W-1:0] read_data,
	input  logic                       irq,
	output int                         failures,
	output int                         outstanding
);
	import stt_pkg::*;

	localparam int CW = COUNT_WIDTH_DEF;

	typedef struct packed {
		logic [DATA_W-1:0] read_data;
		logic              irq;
	} timer_reply_t;

	// Shadow copy of the timer registers
	logic          en_q;
	logic          ie_q;
	logic          core_clk_q;
	logic          one_shot_q;
	logic          flag_q;
	logic [CW-1:0] reload_q;
	logic [CW-1:0] current_q;
	int unsigned   prescale_q;

	timer_reply_t replies_due[$];
	int           fail_count;
	int           due_count;

	assign failures    = fail_count;
	assign outstanding = due_count;

	// One count of the down counter; returns the interrupt
	function automatic logic count_down();
		logic fire;
		fire = 1'b0;
		if (current_q == '0) begin
			current_q = reload_q;
		end else begin
			current_q = current_q - 1'b1;
			if (current_q == '0) begin
				flag_q = 1'b1;
				fire   = ie_q;
				if (one_shot_q) begin
					en_q      = 1'b0;
					ie_q      = 1'b0;
					reload_q  = '0;
					current_q = '0;
				end
			end
		end
		return fire;
	endfunction

	function automatic logic timer_tick();
		if (!en_q)
			return 1'b0;
		if (core_clk_q)
			return count_down();
		if (prescale_q + 1 >= SLOW_DIVIDE_DEF) begin
			prescale_q = 0;
			return count_down();
		end
		prescale_q++;
		return 1'b0;
	endfunction

	function automatic timer_reply_t apply_beat(logic [CMD_W-1:0] c, logic [SEL_W-1:0] s,
			logic [DATA_W-1:0] d);
		timer_reply_t r;
		r = '0;
		case (c)
			CMD_TICK: r.irq = timer_tick();
			CMD_READ: begin
				case (s)
					REG_CTRL: begin
						r.read_data[CTRL_EN_BIT]   = en_q;
						r.read_data[CTRL_IE_BIT]   = ie_q;
						r.read_data[CTRL_CLK_BIT]  = core_clk_q;
						r.read_data[CTRL_ONE_BIT]  = one_shot_q;
						r.read_data[CTRL_FLAG_BIT] = flag_q;
						flag_q = 1'b0;
					end
					REG_RELOAD:  r.read_data[CW-1:0] = reload_q;
					REG_CURRENT: r.read_data[CW-1:0] = current_q;
					default: ;
				endcase
			end
			CMD_WRITE: begin
				case (s)
					REG_CTRL: begin
						en_q       = d[CTRL_EN_BIT];
						ie_q       = d[CTRL_IE_BIT];
						core_clk_q = d[CTRL_CLK_BIT];
						one_shot_q = d[CTRL_ONE_BIT];
					end
					REG_RELOAD: reload_q = d[CW-1:0];
					REG_CURRENT: begin
						current_q = '0;
						flag_q    = 1'b0;
					end
					default: ;
				endcase
			end
			default: ;
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		timer_reply_t want;
		if (!arst_n) begin
			en_q       = 1'b0;
			ie_q       = 1'b0;
			core_clk_q = 1'b0;
			one_shot_q = 1'b0;
			flag_q     = 1'b0;
			reload_q   = '0;
			current_q  = '0;
			prescale_q = 0;
			replies_due.delete();
			fail_count = 0;
			due_count  = 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (replies_due.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: unexpected reply read_data=%h irq=%b",
							$realtime, read_data, irq);
				end else begin
					want = replies_due.pop_front();
					if (read_data !== want.read_data || irq !== want.irq) begin
						fail_count++;
						if (fail_count <= 10)
							$display("%0t: reply mismatch read_data exp %h got %h, irq exp %b got %b",
								$realtime, want.read_data, read_data, want.irq, irq);
					end
				end
			end
			if (item_valid && !item_stall)
				replies_due.push_back(apply_beat(cmd, reg_sel, write_data));
			due_count = replies_due.size();
		end
	end

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import stt_pkg::*;

	// Codes the block must ignore: a fourth command and a fourth register
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam logic [SEL_W-1:0] REG_UNUSED = 2'd3;

	localparam int RANDOM_BEATS = 1050;
	localparam int IDLE_PCT     = 28;

	logic              clk;
	logic              arst_n;
	logic              item_valid;
	logic              item_stall;
	logic [CMD_W-1:0]  cmd;
	logic [SEL_W-1:0]  reg_sel;
	logic [DATA_W-1:0] write_data;
	logic              result_valid;
	logic              result_stall;
	logic [DATA_W-1:0] read_data;
	logic              irq;
	logic              calm;
	int                failures;
	int                outstanding;

	system_tick_down_counter_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.cmd          (cmd),
		.reg_sel      (reg_sel),
		.write_data   (write_data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.read_data    (read_data),
		.irq          (irq)
	);

	stt_timer_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.cmd          (cmd),
		.reg_sel      (reg_sel),
		.write_data   (write_data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.read_data    (read_data),
		.irq          (irq),
		.failures     (failures),
		.outstanding  (outstanding)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Receiver back-pressure: stall on about 28 percent of cycles, none while calm
	always @(posedge clk) begin
		if (!arst_n || calm)
			result_stall <= 1'b0;
		else
			result_stall <= ($urandom_range(0, 99) < IDLE_PCT);
	end

	// Drive one beat: idle at random first, then hold the payload until accepted
	task automatic send_beat(input logic [CMD_W-1:0] c, input logic [SEL_W-1:0] s,
			input logic [DATA_W-1:0] d);
		while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		cmd        <= c;
		reg_sel    <= s;
		write_data <= d;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
	endtask

	// Pick a random beat. Ticks dominate so the counter keeps wrapping; reload
	// values stay mostly tiny so zero is reached often, with a rare full-width one.
	task automatic pick_beat(output logic [CMD_W-1:0] c, output logic [SEL_W-1:0] s,
			output logic [DATA_W-1:0] d);
		int unsigned roll;
		roll = $urandom_range(0, 99);
		s    = SEL_W'($urandom_range(0, 2));
		d    = $urandom();
		if (roll < 2)
			c = CMD_UNUSED;
		else if (roll < 62)
			c = CMD_TICK;
		else if (roll < 77)
			c = CMD_READ;
		else
			c = CMD_WRITE;
		if ($urandom_range(0, 49) == 0)
			s = REG_UNUSED;
		if (c == CMD_WRITE && s == REG_CTRL && $urandom_range(0, 4) != 0)
			d[CTRL_EN_BIT] = 1'b1;
		if (c == CMD_WRITE && s == REG_RELOAD && $urandom_range(0, 7) != 0)
			d = {d[31:24], 16'h0, 8'($urandom_range(0, 6))};
	endtask

	initial begin
		logic [CMD_W-1:0]  c;
		logic [SEL_W-1:0]  s;
		logic [DATA_W-1:0] d;
		int                counted;

		// Every input known from time zero while reset is held
		arst_n     = 1'b0;
		item_valid = 1'b0;
		cmd        = CMD_TICK;
		reg_sel    = REG_CTRL;
		write_data = '0;
		calm       = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset contents, reload width truncation, ignored control bits
		send_beat(CMD_READ,  REG_CTRL,   32'h0);
		send_beat(CMD_WRITE, REG_RELOAD, 32'hFFFF_FFFF);
		send_beat(CMD_READ,  REG_RELOAD, 32'h0);
		send_beat(CMD_WRITE, REG_RELOAD, 32'h0000_0002);
		// Periodic on core clock with interrupt: load, count, fire
		send_beat(CMD_WRITE, REG_CTRL,   32'hFFFF_FFF7);
		repeat (3) send_beat(CMD_TICK, REG_CTRL, 32'hFFFF_FFFF);
		// Control read returns the count flag, then clears it
		send_beat(CMD_READ,  REG_CTRL,   32'h0);
		send_beat(CMD_READ,  REG_CTRL,   32'h0);
		// One-shot: after the interval, enable, interrupt and reload drop
		send_beat(CMD_WRITE, REG_CTRL,   32'h0000_000F);
		repeat (3) send_beat(CMD_TICK, REG_CTRL, 32'h0);
		send_beat(CMD_READ,  REG_CTRL,   32'h0);
		send_beat(CMD_READ,  REG_RELOAD, 32'h0);
		// Disabled timer holds; a write of any value clears the current value
		send_beat(CMD_TICK,  REG_CTRL,   32'h0);
		send_beat(CMD_WRITE, REG_CURRENT, 32'hFFFF_FFFF);
		// Divided clock with reload zero: counter parks at zero, no flag
		send_beat(CMD_WRITE, REG_CTRL,   32'h0000_0003);
		repeat (2) send_beat(CMD_TICK, REG_CTRL, 32'h0);
		send_beat(CMD_READ,  REG_CURRENT, 32'h0);
		// Unknown selector and unknown command are ignored
		send_beat(CMD_READ,  REG_UNUSED, 32'h0);
		send_beat(CMD_WRITE, REG_UNUSED, 32'hFFFF_FFFF);
		send_beat(CMD_UNUSED, REG_CTRL,  32'hFFFF_FFFF);

		// Random traffic; a stretch in the middle runs with no idling on either side
		counted = 0;
		while (counted < RANDOM_BEATS) begin
			calm <= (counted >= 450 && counted < 700);
			pick_beat(c, s, d);
			send_beat(c, s, d);
			if (c != CMD_UNUSED && s != REG_UNUSED)
				counted++;
		end
		calm       <= 1'b0;
		item_valid <= 1'b0;

		// Drain: let the checker log the last beat, wait for every reply,
		// then wait on for strays
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (failures == 0 && outstanding == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#2ms;
		$display("simulation failed");
		$finish;
	end

endmodule
